[rtl/chc_pkg.sv]
// Shared constants and the arctangent table for the compass heading calibration block.
package chc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int NUM_CAL           = 8;
    localparam int CAL_W             = 9;
    localparam int CAL_IDX_W         = 3;
    localparam int XY_W              = 34;
    localparam int Z_W               = 34;
    localparam int DIV_Q_W           = 9;
    localparam int HEAD_MAX          = 360;
    localparam int WRAP_BASE         = 315;
    localparam int SEG_DEG           = 45;
    localparam int DEG_SCALE         = 57;

    localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;

    localparam logic [CAL_W-1:0] CAL_RESET [NUM_CAL] = '{
        9'd47, 9'd110, 9'd170, 9'd193, 9'd212, 9'd256, 9'd270, 9'd334
    };

    // atan(2^-i) in Q2.30 radians, truncated
    function automatic logic signed [Z_W-1:0] f_atan(input int unsigned i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            0:  v = 34'sh3243F6A8;
            1:  v = 34'sh1DAC6705;
            2:  v = 34'sh0FADBAFC;
            3:  v = 34'sh07F56EA6;
            4:  v = 34'sh03FEAB76;
            5:  v = 34'sh01FFD55B;
            6:  v = 34'sh00FFFAAA;
            7:  v = 34'sh007FFF55;
            8:  v = 34'sh003FFFEA;
            9:  v = 34'sh001FFFFD;
            10: v = 34'sh000FFFFF;
            11: v = 34'sh0007FFFF;
            12: v = 34'sh0003FFFF;
            13: v = 34'sh0001FFFF;
            14: v = 34'sh0000FFFF;
            15: v = 34'sh00007FFF;
            16: v = 34'sh00003FFF;
            17: v = 34'sh00001FFF;
            18: v = 34'sh00000FFF;
            19: v = 34'sh000007FF;
            20: v = 34'sh000003FF;
            21: v = 34'sh000001FF;
            22: v = 34'sh000000FF;
            23: v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/compass_heading_calibration.sv]
// Compass heading calibration: CORDIC raw heading, then piecewise-linear correction.
//
//  channel   | ports                                         | flow
//  ----------+-----------------------------------------------+------------------------------
//  sample in | start, busy, i_mag_x, i_mag_y                 | request taken on start & !busy
//  result    | o_valid, o_raw_heading, o_true_heading        | one-cycle strobe, no back-pressure
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data               | write on i_cfg_we, no wait
//
// One request per cycle; busy is always low. The pipeline registers, in order:
// capture, one CORDIC stage per iteration, scale, saturate, segment select,
// numerator, divider load and nine restoring divider stages, output register.
// Synchronous active-low reset clears the valid chain and reloads the calibration points.
// The receiver cannot stall; every request yields exactly one result.
module compass_heading_calibration
    import chc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [15:0]      i_mag_x,
    input  logic signed [15:0]      i_mag_y,
    input  logic                    i_cfg_we,
    input  logic [CAL_IDX_W-1:0]    i_cfg_idx,
    input  logic [CAL_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic [CAL_W-1:0]        o_raw_heading,
    output logic [CAL_W-1:0]        o_true_heading
);

    localparam int HW  = CAL_W + FRAC_BITS;
    localparam int DW  = 10 + FRAC_BITS;
    localparam int DDW = 11 + FRAC_BITS;
    localparam int NW  = 21 + FRAC_BITS;
    localparam int RW  = NW - 1;
    localparam int PW  = 41;
    localparam int SH  = 30 - FRAC_BITS;
    localparam logic signed [PW-1:0]  P_OFS  = PW'(180) <<< 30;
    localparam logic signed [PW-1:0]  H_LIM  = (PW'(HEAD_MAX) <<< FRAC_BITS) - PW'(1);
    localparam logic signed [DDW-1:0] FULL_D = DDW'(HEAD_MAX) <<< FRAC_BITS;

    typedef struct packed {
        logic             v;
        logic             zero;
        logic             sat;
        logic [RW-1:0]    rem;
        logic [DW-1:0]    den;
        logic [DIV_Q_W-1:0] q;
        logic [CAL_W-1:0] raw;
    } t_div;

    assign busy = 1'b0;

    // calibration points
    logic [CAL_W-1:0] r_cal [NUM_CAL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= CAL_RESET;
        end else if (i_cfg_we) begin
            r_cal[i_cfg_idx] <= i_cfg_data;
        end
    end

    // capture and pre-rotation
    logic signed [XY_W-1:0] r_x [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] r_y [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  r_z [CORDIC_STAGES+1];
    logic                   r_cv [CORDIC_STAGES+1];
    logic                   r_cz [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] n_x0, n_y0;
    logic signed [Z_W-1:0]  n_z0;

    always_comb begin
        n_x0 = {{3{i_mag_x[15]}}, i_mag_x, 15'b0};
        n_y0 = {{3{i_mag_y[15]}}, i_mag_y, 15'b0};
        n_z0 = '0;
        if (i_mag_x[15]) begin
            n_x0 = -n_x0;
            n_y0 = -n_y0;
            n_z0 = i_mag_y[15] ? -PI_Q30 : PI_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else begin
            r_cv[0] <= start & ~busy;
        end
        r_x[0]  <= n_x0;
        r_y[0]  <= n_y0;
        r_z[0]  <= n_z0;
        r_cz[0] <= (i_mag_x == 16'sd0) && (i_mag_y == 16'sd0);
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        logic signed [XY_W-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else begin
                r_cv[i+1] <= r_cv[i];
            end
            r_cz[i+1] <= r_cz[i];
            if (!r_y[i][XY_W-1]) begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + f_atan(i);
            end else begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - f_atan(i);
            end
        end
    end

    // scale to degrees
    logic                   r_pv;
    logic signed [PW-1:0]   r_p;
    logic signed [PW-1:0]   w_zx;

    assign w_zx = r_cz[CORDIC_STAGES] ? '0 : PW'(r_z[CORDIC_STAGES]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= r_cv[CORDIC_STAGES];
        end
        r_p <= w_zx * PW'(DEG_SCALE) + P_OFS;
    end

    // saturate raw heading
    logic                 r_hv;
    logic [HW-1:0]        r_h;
    logic signed [PW-1:0] w_hs;
    logic [HW-1:0]        n_h;

    assign w_hs = r_p >>> SH;

    always_comb begin
        if (w_hs < 0) begin
            n_h = '0;
        end else if (w_hs > H_LIM) begin
            n_h = H_LIM[HW-1:0];
        end else begin
            n_h = w_hs[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else begin
            r_hv <= r_pv;
        end
        r_h <= n_h;
    end

    // segment select, last match wins
    logic                   r_sv, r_sz;
    logic [DW-1:0]          r_sden;
    logic signed [DDW-1:0]  r_sd;
    logic [CAL_W-1:0]       r_sbase, r_sraw;
    logic                   n_sz;
    logic [DW-1:0]          n_sden;
    logic signed [DDW-1:0]  n_sd;
    logic [CAL_W-1:0]       n_sbase;

    always_comb begin
        logic [HW-1:0]         lo, hi, sw_f, s_f;
        logic signed [10:0]    wspan;
        logic signed [DDW-1:0] hd;
        hd      = $signed({2'b00, r_h});
        n_sz    = 1'b1;
        n_sden  = '0;
        n_sd    = '0;
        n_sbase = '0;
        for (int k = 0; k < NUM_CAL - 1; k++) begin
            lo = {r_cal[k], {FRAC_BITS{1'b0}}};
            hi = {r_cal[k+1], {FRAC_BITS{1'b0}}};
            if (lo < r_h && r_h <= hi) begin
                n_sz    = 1'b0;
                n_sden  = {1'b0, hi - lo};
                n_sd    = hd - $signed({2'b00, lo});
                n_sbase = CAL_W'(SEG_DEG * k);
            end
        end
        sw_f  = {r_cal[0], {FRAC_BITS{1'b0}}};
        s_f   = {r_cal[NUM_CAL-1], {FRAC_BITS{1'b0}}};
        wspan = 11'sd360 - $signed({2'b00, r_cal[NUM_CAL-1]})
              + $signed({2'b00, r_cal[0]});
        if (s_f < r_h) begin
            n_sz    = (wspan <= 0);
            n_sden  = {wspan[9:0], {FRAC_BITS{1'b0}}};
            n_sd    = hd - $signed({2'b00, s_f});
            n_sbase = CAL_W'(WRAP_BASE);
        end
        if (r_h <= sw_f) begin
            n_sz    = (wspan <= 0);
            n_sden  = {wspan[9:0], {FRAC_BITS{1'b0}}};
            n_sd    = hd + FULL_D - $signed({2'b00, s_f});
            n_sbase = CAL_W'(WRAP_BASE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else begin
            r_sv <= r_hv;
        end
        r_sz    <= n_sz;
        r_sden  <= n_sden;
        r_sd    <= n_sd;
        r_sbase <= n_sbase;
        r_sraw  <= r_h[HW-1:FRAC_BITS];
    end

    // numerator base*den + 45*d
    logic                   r_nv, r_nz;
    logic signed [NW-1:0]   r_n;
    logic [DW-1:0]          r_nden;
    logic [CAL_W-1:0]       r_nraw;
    logic [DW+CAL_W-1:0]    w_bd;
    logic signed [NW-1:0]   w_d45;

    assign w_bd  = (DW + CAL_W)'(r_sbase) * (DW + CAL_W)'(r_sden);
    assign w_d45 = NW'(r_sd) * NW'(SEG_DEG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else begin
            r_nv <= r_sv;
        end
        r_nz   <= r_sz;
        r_n    <= $signed(NW'(w_bd)) + w_d45;
        r_nden <= r_sden;
        r_nraw <= r_sraw;
    end

    // restoring divider, one quotient bit per stage
    t_div r_div [DIV_Q_W+1];
    t_div n_div0;

    always_comb begin
        n_div0.v    = r_nv;
        n_div0.zero = r_nz | r_n[NW-1];
        n_div0.sat  = r_n[RW-1:0] >= (RW'(r_nden) << DIV_Q_W);
        n_div0.rem  = r_n[RW-1:0];
        n_div0.den  = r_nden;
        n_div0.q    = '0;
        n_div0.raw  = r_nraw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div[0] <= '0;
        end else begin
            r_div[0] <= n_div0;
        end
    end

    for (genvar j = 0; j < DIV_Q_W; j++) begin : g_div
        localparam int B = DIV_Q_W - 1 - j;
        logic [RW-1:0] dsh;
        t_div          nd;
        assign dsh = RW'(r_div[j].den) << B;
        always_comb begin
            nd = r_div[j];
            if (r_div[j].rem >= dsh) begin
                nd.rem  = r_div[j].rem - dsh;
                nd.q[B] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[j+1] <= '0;
            end else begin
                r_div[j+1] <= nd;
            end
        end
    end

    // clamp and output
    logic             r_ov;
    logic [CAL_W-1:0] r_oraw, r_otrue;
    logic [CAL_W-1:0] n_otrue;
    t_div             w_dl;

    assign w_dl = r_div[DIV_Q_W];

    always_comb begin
        if (w_dl.zero) begin
            n_otrue = '0;
        end else if (w_dl.sat || w_dl.q > CAL_W'(HEAD_MAX)) begin
            n_otrue = CAL_W'(HEAD_MAX);
        end else begin
            n_otrue = w_dl.q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= w_dl.v;
        end
        r_oraw  <= w_dl.raw;
        r_otrue <= n_otrue;
    end

    assign o_valid        = r_ov;
    assign o_raw_heading  = r_oraw;
    assign o_true_heading = r_otrue;

endmodule
